@@ rtl/core/gbfps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gbfps_pkg;

  // Default grid edge length in cells.
  localparam int unsigned GRID_SIZE_DEF = 8;

  // Result status codes.
  localparam logic [1:0] ST_POINT   = 2'd0;
  localparam logic [1:0] ST_SAME    = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_NO_PATH = 2'd3;

  // Input item opcodes.
  localparam logic OPC_WRITE  = 1'b0;
  localparam logic OPC_SEARCH = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [2:0] pos_x;
    logic [2:0] pos_z;
    logic [2:0] goal_x;
    logic [2:0] goal_z;
    logic       blocked;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] point_x;
    logic [2:0] point_z;
    logic       last;
  } out_item_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_SCAN,
    OP_EXPAND,
    OP_NEIGH,
    OP_WALK_RD,
    OP_WALK_UPD,
    OP_EMIT_RD,
    OP_EMIT_PATH,
    OP_EMIT_STATUS
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] st;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic off_grid;
    logic same;
    logic goal_blk;
    logic scan_done;
    logic best_vld;
    logic best_is_goal;
    logic nb_last;
    logic walk_done;
    logic len_zero;
    logic out_free;
  } dp_sts_t;

  // Neighbour offsets in visiting order.
  function automatic logic [1:0] nb_dx(input logic [2:0] n);
    logic [1:0] d;
    unique case (n)
      3'd0, 3'd1, 3'd2: d = 2'b11;
      3'd3, 3'd4:       d = 2'b00;
      default:          d = 2'b01;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] nb_dz(input logic [2:0] n);
    logic [1:0] d;
    unique case (n)
      3'd0, 3'd4, 3'd5: d = 2'b11;
      3'd1, 3'd6:       d = 2'b00;
      default:          d = 2'b01;
    endcase
    return d;
  endfunction

  function automatic logic [5:0] sq3(input logic [2:0] a, input logic [2:0] b);
    logic [2:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {3'b000, d} * {3'b000, d};
  endfunction

  // Squared distance to start plus squared distance to goal; cell is {x, z}.
  function automatic logic [7:0] score(input logic [5:0] c,
                                       input logic [2:0] sx, input logic [2:0] sz,
                                       input logic [2:0] gx, input logic [2:0] gz);
    logic [6:0] ds;
    logic [6:0] dg;
    ds = {1'b0, sq3(c[5:3], sx)} + {1'b0, sq3(c[2:0], sz)};
    dg = {1'b0, sq3(c[5:3], gx)} + {1'b0, sq3(c[2:0], gz)};
    return {1'b0, ds} + {1'b0, dg};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/gbfps_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gbfps_dp #(
  parameter int unsigned GRID_SIZE = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  gbfps_pkg::in_item_t  in_data,
  input  gbfps_pkg::ctl_cmd_t  cmd,
  output gbfps_pkg::dp_sts_t   sts,
  input  wire                  out_stall,
  output logic                 out_valid,
  output gbfps_pkg::out_item_t out_data
);
  import gbfps_pkg::*;

  localparam logic [3:0] GS = 4'(GRID_SIZE);

  // Captured item fields. Cells are kept as {x, z}.
  logic       op_r;
  logic [2:0] sx_r, sz_r, gx_r, gz_r;

  logic [63:0] occ_r;
  logic [63:0] open_r;
  logic [63:0] closed_r;

  logic [5:0] order_mem [64];
  logic [5:0] parent_mem [64];
  logic [5:0] path_mem [64];
  logic [5:0] order_q_r;
  logic [5:0] parent_q_r;
  logic [5:0] path_q_r;

  logic       rvld_r;
  logic [6:0] cnt_r;
  logic [6:0] idx_r;
  logic [5:0] best_r;
  logic       best_vld_r;
  logic [5:0] cur_r;
  logic [2:0] nb_r;
  logic [5:0] walk_r;
  logic [5:0] len_r;

  logic        out_vld_r;
  logic        out_vld_nxt;
  out_item_t   out_r;

  logic [5:0] start_c, goal_c;
  logic       cand;
  logic [1:0] dx, dz;
  logic [3:0] nx4, nz4;
  logic [5:0] adj;
  logic       elig, new_open, upd_par;
  logic [5:0] len_dec;

  assign start_c = {sx_r, sz_r};
  assign goal_c  = {gx_r, gz_r};
  assign len_dec = len_r - 6'd1;

  // Scan candidate: open and strictly better than the best so far.
  assign cand = open_r[order_q_r] &&
                (!best_vld_r ||
                 (score(order_q_r, sx_r, sz_r, gx_r, gz_r) <
                  score(best_r, sx_r, sz_r, gx_r, gz_r)));

  // Neighbour of the expanded cell; a step below zero lands past the edge and is rejected.
  always_comb begin
    dx  = nb_dx(nb_r);
    dz  = nb_dz(nb_r);
    nx4 = {1'b0, cur_r[5:3]} + {{2{dx[1]}}, dx};
    nz4 = {1'b0, cur_r[2:0]} + {{2{dz[1]}}, dz};
    adj = {nx4[2:0], nz4[2:0]};
    elig = (nx4 < GS) && (nz4 < GS) && !closed_r[adj] && !occ_r[adj];
    new_open = elig && !open_r[adj];
    upd_par  = elig && open_r[adj] &&
               (score(adj, sx_r, sz_r, gx_r, gz_r) < score(cur_r, sx_r, sz_r, gx_r, gz_r));
  end

  // A result leaves on a transfer; a new one fills the register.
  always_comb begin
    out_vld_nxt = out_vld_r && out_stall;
    if (cmd.op == OP_EMIT_PATH || cmd.op == OP_EMIT_STATUS) begin
      out_vld_nxt = 1'b1;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.is_write     = (op_r == OPC_WRITE);
    sts.off_grid     = ({1'b0, sx_r} >= GS) || ({1'b0, sz_r} >= GS) ||
                       ({1'b0, gx_r} >= GS) || ({1'b0, gz_r} >= GS);
    sts.same         = (start_c == goal_c);
    sts.goal_blk     = occ_r[goal_c];
    sts.scan_done    = (idx_r >= cnt_r) && !rvld_r;
    sts.best_vld     = best_vld_r;
    sts.best_is_goal = (best_r == goal_c);
    sts.nb_last      = (nb_r == 3'd7);
    sts.walk_done    = (walk_r == start_c) || (len_r == 6'd63);
    sts.len_zero     = (len_r == 6'd0);
    sts.out_free     = !out_vld_r || !out_stall;
  end

  // Control state of the search.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      open_r     <= '0;
      closed_r   <= '0;
      rvld_r     <= 1'b0;
      best_vld_r <= 1'b0;
      cnt_r      <= '0;
      idx_r      <= '0;
      nb_r       <= '0;
      len_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      unique case (cmd.op)
        OP_LOAD: begin
          if (in_data.opcode == OPC_WRITE && {1'b0, in_data.pos_x} < GS &&
              {1'b0, in_data.pos_z} < GS) begin
            occ_r[{in_data.pos_x, in_data.pos_z}] <= in_data.blocked;
          end
        end
        OP_INIT: begin
          closed_r       <= '0;
          open_r         <= 64'd1 << start_c;
          cnt_r          <= 7'd1;
          idx_r          <= '0;
          rvld_r         <= 1'b0;
          best_vld_r     <= 1'b0;
        end
        OP_SCAN: begin
          rvld_r <= (idx_r < cnt_r);
          if (idx_r < cnt_r) begin
            idx_r <= idx_r + 7'd1;
          end
          if (rvld_r && cand) begin
            best_vld_r <= 1'b1;
          end
        end
        OP_EXPAND: begin
          open_r[best_r]   <= 1'b0;
          closed_r[best_r] <= 1'b1;
          nb_r             <= '0;
          len_r            <= '0;
        end
        OP_NEIGH: begin
          if (new_open) begin
            open_r[adj] <= 1'b1;
            if (cnt_r < 7'd64) begin
              cnt_r <= cnt_r + 7'd1;
            end
          end
          nb_r <= nb_r + 3'd1;
          if (nb_r == 3'd7) begin
            idx_r      <= '0;
            rvld_r     <= 1'b0;
            best_vld_r <= 1'b0;
          end
        end
        OP_WALK_RD: len_r <= len_r + 6'd1;
        OP_EMIT_RD: len_r <= len_dec;
        default: begin
        end
      endcase
    end
  end

  // Payload registers and memories.
  always_ff @(posedge clk) begin
    order_q_r  <= order_mem[idx_r[5:0]];
    parent_q_r <= parent_mem[walk_r];
    unique case (cmd.op)
      OP_LOAD: begin
        op_r <= in_data.opcode;
        sx_r <= in_data.pos_x;
        sz_r <= in_data.pos_z;
        gx_r <= in_data.goal_x;
        gz_r <= in_data.goal_z;
      end
      OP_INIT: order_mem[0] <= start_c;
      OP_SCAN: begin
        if (rvld_r && cand) begin
          best_r <= order_q_r;
        end
      end
      OP_EXPAND: begin
        cur_r  <= best_r;
        walk_r <= goal_c;
      end
      OP_NEIGH: begin
        if (new_open || upd_par) begin
          parent_mem[adj] <= cur_r;
        end
        if (new_open && cnt_r < 7'd64) begin
          order_mem[cnt_r[5:0]] <= adj;
        end
      end
      OP_WALK_RD: path_mem[len_r] <= walk_r;
      OP_WALK_UPD: walk_r <= parent_q_r;
      // The path point is read once and held while the output is busy.
      OP_EMIT_RD: path_q_r <= path_mem[len_dec];
      OP_EMIT_PATH: out_r <= '{status: ST_POINT, point_x: path_q_r[5:3],
                                point_z: path_q_r[2:0], last: (len_r == 6'd0)};
      OP_EMIT_STATUS: out_r <= '{status: cmd.st, point_x: 3'd0, point_z: 3'd0,
                                  last: 1'b1};
      default: begin
      end
    endcase
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ rtl/core/gbfps_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gbfps_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  gbfps_pkg::dp_sts_t  sts,
  output gbfps_pkg::ctl_cmd_t cmd
);
  import gbfps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_EXPAND,
    S_NEIGH,
    S_WALK_RD,
    S_WALK_UPD,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_STATUS_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] st_r, st_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Sequencing of one item.
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd.op    = OP_NONE;
    cmd.st    = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.is_write) begin
          state_nxt = S_IDLE;
        end else if (sts.off_grid) begin
          st_nxt    = ST_NO_PATH;
          state_nxt = S_STATUS_OUT;
        end else if (sts.same) begin
          st_nxt    = ST_SAME;
          state_nxt = S_STATUS_OUT;
        end else if (sts.goal_blk) begin
          st_nxt    = ST_BLOCKED;
          state_nxt = S_STATUS_OUT;
        end else begin
          cmd.op    = OP_INIT;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (sts.scan_done) begin
          if (sts.best_vld) begin
            state_nxt = S_EXPAND;
          end else begin
            st_nxt    = ST_NO_PATH;
            state_nxt = S_STATUS_OUT;
          end
        end
      end
      S_EXPAND: begin
        cmd.op    = OP_EXPAND;
        state_nxt = sts.best_is_goal ? S_WALK_RD : S_NEIGH;
      end
      S_NEIGH: begin
        cmd.op = OP_NEIGH;
        if (sts.nb_last) begin
          state_nxt = S_SCAN;
        end
      end
      S_WALK_RD: begin
        if (sts.walk_done) begin
          state_nxt = S_EMIT_RD;
        end else begin
          cmd.op    = OP_WALK_RD;
          state_nxt = S_WALK_UPD;
        end
      end
      S_WALK_UPD: begin
        cmd.op    = OP_WALK_UPD;
        state_nxt = S_WALK_RD;
      end
      S_EMIT_RD: begin
        cmd.op    = OP_EMIT_RD;
        state_nxt = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (sts.out_free) begin
          cmd.op    = OP_EMIT_PATH;
          state_nxt = sts.len_zero ? S_IDLE : S_EMIT_RD;
        end
      end
      S_STATUS_OUT: begin
        if (sts.out_free) begin
          cmd.op    = OP_EMIT_STATUS;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_POINT;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/grid_best_first_path_search.sv @@
// Best-first path search on a square occupancy grid with 8-neighbour moves.
// Input channel (in_valid / in_stall / in_data): an opcode 0 item writes one
// occupancy cell and gives no result; an opcode 1 item searches from the
// start cell to the goal cell. A transfer takes place when valid is high and
// stall is low. The block takes one item at a time; in_stall stays high
// until the previous item has put its last result in the output register.
// A search picks each cell from the open list by a scan of the list,
// expands it into its neighbours, then walks the parent links back from
// the goal and streams the path; the open list scan dominates.
// Output channel (out_valid / out_stall / out_data): path points from the
// first step to the goal, or one status result; last marks the final one.
// A stalled result holds in the output register and the next result waits for it.
// Reset (synchronous, rst_n low) frees every grid cell and drops any
// pending result.
`timescale 1ns / 1ps
`default_nettype none

module grid_best_first_path_search #(
  parameter int unsigned GRID_SIZE = gbfps_pkg::GRID_SIZE_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  gbfps_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output gbfps_pkg::out_item_t out_data
);
  import gbfps_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  gbfps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbfps_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/core/gbfps_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gbfps_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input wire                  out_valid,
  input wire                  out_stall,
  input gbfps_pkg::out_item_t out_data
);
  import gbfps_pkg::*;

  // A held result stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset drops any pending result.
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Status results are final and carry no point; non-final ones are points.
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_POINT) ||
                  (out_data.last && out_data.point_x == 3'd0 &&
                   out_data.point_z == 3'd0))
    else $error("malformed status result");

  // The block is busy the cycle after any transfer in.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken back to back");

endmodule

bind grid_best_first_path_search gbfps_checker u_gbfps_checker (.*);

`default_nettype wire
